FILE: rtl/core/mcm_bist_pkg.sv
`default_nettype none

package mcm_bist_pkg;

  // Configuration register file
  localparam int unsigned CfgDataWidth = 20;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_RANGE_LOW     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_RANGE_HIGH    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_HALT_ON_ERROR = 2'd2;

  localparam logic [CfgDataWidth-1:0] RANGE_LOW_RESET  = 20'h00000;
  localparam logic [CfgDataWidth-1:0] RANGE_HIGH_RESET = 20'h1FFFF;

  // Stream widths
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned InUserWidth  = 1;
  localparam int unsigned OutDataWidth = 64;

  // Field widths
  localparam int unsigned ReportAddrWidth = 20;
  localparam int unsigned ByteWidth       = 8;
  localparam int unsigned BitIdxWidth     = 3;
  localparam int unsigned ElemWidth       = 3;
  localparam int unsigned StepWidth       = 2;

  // Input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_ACK   = 1'b1;

  // March elements
  localparam logic [ElemWidth-1:0] EL_FILL      = 3'd0;
  localparam logic [ElemWidth-1:0] EL_UP_R0W1R1 = 3'd1;
  localparam logic [ElemWidth-1:0] EL_UP_R1W0   = 3'd2;
  localparam logic [ElemWidth-1:0] EL_DN_R0W1   = 3'd3;
  localparam logic [ElemWidth-1:0] EL_DN_R1W0   = 3'd4;
  localparam logic [ElemWidth-1:0] EL_FINAL     = 3'd5;

  // Access steps within one bit of an element
  localparam logic [StepWidth-1:0] STEP_READ   = 2'd0;
  localparam logic [StepWidth-1:0] STEP_WRITE  = 2'd1;
  localparam logic [StepWidth-1:0] STEP_VERIFY = 2'd2;

  localparam logic [BitIdxWidth-1:0] BIT_FIRST = 3'd0;
  localparam logic [BitIdxWidth-1:0] BIT_LAST  = 3'd7;

endpackage

`default_nettype wire

FILE: rtl/core/march_c_minus_memory_bist_core.sv
// An accepted input beat's result is registered onto the master side in the next cycle.
// Throughput: one beat per cycle while the master side keeps up; the march's next step is
// decided by a single combinational pass between the input handshake and the registered result.
// A beat enters while the slot is empty or draining; a stalled master holds tready low.
// Reset (rst_ni low, asynchronous): sequencer idle, status and failure records cleared,
// range_low = 0, range_high = 0x1FFFF, halt_on_error = 1; no result pending.
`default_nettype none

module march_c_minus_memory_bist_core #(
  parameter int unsigned ADDR_WIDTH = 20
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Configuration write port
  input  wire logic                                   cfg_we_i,
  input  wire logic [mcm_bist_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire logic [mcm_bist_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  // Slave side
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // tdata: read_data[7:0]
  input  wire logic [mcm_bist_pkg::InDataWidth-1:0]   s_axis_tdata_i,
  // tuser: op[0]
  input  wire logic [mcm_bist_pkg::InUserWidth-1:0]   s_axis_tuser_i,
  // Master side
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // tdata: req_valid[0], req_write[1], req_addr[21:2], req_wdata[29:22], running[30],
  //        finished[31], failed[32], fail_addr[52:33], fail_bit[55:53],
  //        fail_element[58:56], zero[63:59]
  output logic [mcm_bist_pkg::OutDataWidth-1:0]       m_axis_tdata_o
);

  import mcm_bist_pkg::*;

  localparam int unsigned PadWidth = OutDataWidth - (2 + ReportAddrWidth + ByteWidth + 3
                                     + ReportAddrWidth + BitIdxWidth + ElemWidth);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CfgDataWidth-1:0] range_low_q, range_high_q;
  logic                    halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= RANGE_LOW_RESET;
      range_high_q <= RANGE_HIGH_RESET;
      halt_q       <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANGE_LOW:     range_low_q  <= cfg_wdata_i;
        CFG_RANGE_HIGH:    range_high_q <= cfg_wdata_i;
        CFG_HALT_ON_ERROR: halt_q       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Range bounds at the internal address width, read live each step
  logic [ADDR_WIDTH-1:0] lo_addr, hi_addr;
  assign lo_addr = ADDR_WIDTH'(range_low_q);
  assign hi_addr = ADDR_WIDTH'(range_high_q);

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  logic [ElemWidth-1:0]   element_q, element_d;
  logic [StepWidth-1:0]   step_q, step_d;
  logic [ADDR_WIDTH-1:0]  addr_q, addr_d;
  logic [BitIdxWidth-1:0] bit_q, bit_d;
  logic [ByteWidth-1:0]   held_q, held_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   fail_q, fail_d;
  logic [ADDR_WIDTH-1:0]  ff_addr_q, ff_addr_d;
  logic [BitIdxWidth-1:0] ff_bit_q, ff_bit_d;
  logic [ElemWidth-1:0]   ff_elem_q, ff_elem_d;

  logic                   op;
  logic [ByteWidth-1:0]   rdata;
  logic                   in_beat;

  assign op      = s_axis_tuser_i[0];
  assign rdata   = s_axis_tdata_i;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // Mismatch detection for the current access
  logic                   rbit;
  logic                   fail_ev;
  logic [BitIdxWidth-1:0] fail_b;
  logic [BitIdxWidth-1:0] low_set;
  logic                   halted;
  logic [ByteWidth-1:0]   toggled;

  assign rbit    = rdata[bit_q];
  assign toggled = rdata ^ (ByteWidth'(1) << bit_q);

  // Lowest set bit of the returned byte; defaults to the top bit
  always_comb begin
    low_set = BIT_LAST;
    for (int i = ByteWidth - 1; i >= 0; i--) begin
      if (rdata[i]) low_set = BitIdxWidth'(i);
    end
  end

  always_comb begin
    fail_ev = 1'b0;
    fail_b  = bit_q;
    unique case (element_q)
      EL_UP_R0W1R1: begin
        if (step_q == STEP_READ)        fail_ev = rbit;
        else if (step_q != STEP_WRITE)  fail_ev = !rbit;
      end
      EL_UP_R1W0, EL_DN_R1W0: begin
        if (step_q == STEP_READ) fail_ev = !rbit;
      end
      EL_DN_R0W1: begin
        if (step_q == STEP_READ) fail_ev = rbit;
      end
      EL_FINAL: begin
        fail_ev = (rdata != '0);
        fail_b  = low_set;
      end
      default: ;
    endcase
  end

  assign halted = fail_ev && halt_q;

  // Bit/address walk at the end of each bit's accesses
  logic                   walk;
  logic                   walk_desc;
  logic [ElemWidth-1:0]   walk_el;
  logic                   walk_asc;
  logic                   req;

  always_comb begin
    element_d = element_q;
    step_d    = step_q;
    addr_d    = addr_q;
    bit_d     = bit_q;
    held_d    = held_q;
    busy_d    = busy_q;
    done_d    = done_q;
    fail_d    = fail_q;
    ff_addr_d = ff_addr_q;
    ff_bit_d  = ff_bit_q;
    ff_elem_d = ff_elem_q;
    walk      = 1'b0;
    walk_desc = 1'b0;
    walk_el   = EL_FILL;
    walk_asc  = 1'b1;
    req       = 1'b1;

    if (op == OP_START) begin
      if (busy_q) begin
        // Ignore a start mid-test; the outstanding access stays outstanding
        req = 1'b0;
      end else begin
        done_d    = 1'b0;
        fail_d    = 1'b0;
        ff_addr_d = '0;
        ff_bit_d  = '0;
        ff_elem_d = '0;
        held_d    = '0;
        element_d = EL_FILL;
        step_d    = STEP_READ;
        addr_d    = lo_addr;
        bit_d     = BIT_FIRST;
        if (lo_addr > hi_addr) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          busy_d = 1'b1;
        end
      end
    end else if (busy_q) begin
      // Keep only the first failure
      if (fail_ev && !fail_q) begin
        fail_d    = 1'b1;
        ff_addr_d = addr_q;
        ff_bit_d  = fail_b;
        ff_elem_d = element_q;
      end
      if (halted) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        unique case (element_q)
          EL_FILL: begin
            if (addr_q >= hi_addr) begin
              element_d = EL_UP_R0W1R1;
              step_d    = STEP_READ;
              addr_d    = lo_addr;
              bit_d     = BIT_FIRST;
            end else begin
              addr_d = addr_q + ADDR_WIDTH'(1);
            end
          end
          EL_UP_R0W1R1: begin
            if (step_q == STEP_READ) begin
              held_d = toggled;
              step_d = STEP_WRITE;
            end else if (step_q == STEP_WRITE) begin
              step_d = STEP_VERIFY;
            end else begin
              walk    = 1'b1;
              walk_el = EL_UP_R1W0;
            end
          end
          EL_UP_R1W0, EL_DN_R0W1, EL_DN_R1W0: begin
            if (step_q == STEP_READ) begin
              held_d = toggled;
              step_d = STEP_WRITE;
            end else begin
              walk = 1'b1;
              priority if (element_q == EL_UP_R1W0) begin
                walk_el  = EL_DN_R0W1;
                walk_asc = 1'b0;
              end else if (element_q == EL_DN_R0W1) begin
                walk_desc = 1'b1;
                walk_el   = EL_DN_R1W0;
                walk_asc  = 1'b0;
              end else begin
                walk_desc = 1'b1;
                walk_el   = EL_FINAL;
              end
            end
          end
          EL_FINAL: begin
            if (addr_q >= hi_addr) begin
              busy_d = 1'b0;
              done_d = 1'b1;
            end else begin
              addr_d = addr_q + ADDR_WIDTH'(1);
            end
          end
          default: begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        endcase

        if (walk) begin
          step_d = STEP_READ;
          if (!walk_desc) begin
            if (bit_q != BIT_LAST) begin
              bit_d = bit_q + BitIdxWidth'(1);
            end else if (addr_q >= hi_addr) begin
              element_d = walk_el;
              addr_d    = walk_asc ? lo_addr : hi_addr;
              bit_d     = walk_asc ? BIT_FIRST : BIT_LAST;
            end else begin
              addr_d = addr_q + ADDR_WIDTH'(1);
              bit_d  = BIT_FIRST;
            end
          end else begin
            if (bit_q != BIT_FIRST) begin
              bit_d = bit_q - BitIdxWidth'(1);
            end else if (addr_q <= lo_addr) begin
              element_d = walk_el;
              addr_d    = walk_asc ? lo_addr : hi_addr;
              bit_d     = walk_asc ? BIT_FIRST : BIT_LAST;
            end else begin
              addr_d = addr_q - ADDR_WIDTH'(1);
              bit_d  = BIT_LAST;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_q <= EL_FILL;
      step_q    <= STEP_READ;
      addr_q    <= '0;
      bit_q     <= BIT_FIRST;
      held_q    <= '0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      fail_q    <= 1'b0;
      ff_addr_q <= '0;
      ff_bit_q  <= '0;
      ff_elem_q <= '0;
    end else if (in_beat) begin
      element_q <= element_d;
      step_q    <= step_d;
      addr_q    <= addr_d;
      bit_q     <= bit_d;
      held_q    <= held_d;
      busy_q    <= busy_d;
      done_q    <= done_d;
      fail_q    <= fail_d;
      ff_addr_q <= ff_addr_d;
      ff_bit_q  <= ff_bit_d;
      ff_elem_q <= ff_elem_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result beat, formed from the updated state
  // ---------------------------------------------------------------------------
  logic                       rq_valid, rq_write;
  logic [ReportAddrWidth-1:0] rq_addr;
  logic [ByteWidth-1:0]       rq_wdata;
  logic [OutDataWidth-1:0]    res_data;

  always_comb begin
    rq_valid = req && busy_d;
    rq_write = 1'b0;
    rq_addr  = '0;
    rq_wdata = '0;
    if (rq_valid) begin
      rq_addr = ReportAddrWidth'(addr_d);
      if (element_d == EL_FILL) begin
        rq_write = 1'b1;
      end else if (step_d == STEP_WRITE && element_d >= EL_UP_R0W1R1
                   && element_d <= EL_DN_R1W0) begin
        rq_write = 1'b1;
        rq_wdata = held_d;
      end
    end
  end

  assign res_data = {PadWidth'(0), ff_elem_d, ff_bit_d, ReportAddrWidth'(ff_addr_d),
                     fail_d, done_d, busy_d, rq_wdata, rq_addr, rq_write, rq_valid};

  // Output register: take a new beat whenever the slot is empty or draining
  logic                    out_valid_q;
  logic [OutDataWidth-1:0] out_data_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire
